[hw/rtl/pgls_pkg.sv]
// ----------------------------------------------------------------------------
// pgls_pkg
// shared widths and request types of the line search controller and its
// arithmetic units
// ----------------------------------------------------------------------------
package pgls_pkg;

    // default fraction bits and reset tolerance
    localparam int FRAC_BITS_DEF = 16;
    localparam logic [15:0] TOL_RESET = 16'd7;

    // shift-add multiplier widths
    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // restoring divider widths
    localparam int DIV_N_W = 128;
    localparam int DIV_D_W = 64;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } t_div_req;

endpackage

[hw/rtl/pgls_mul.sv]
// ----------------------------------------------------------------------------
// pgls_mul
// unsigned shift-add multiplier, one multiplier bit per cycle, msb first
// ----------------------------------------------------------------------------
module pgls_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pgls_pkg::t_mul_req          i_req,
    output logic                        o_done,
    output logic [pgls_pkg::MUL_P_W-1:0] o_prod
);
    import pgls_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W + 1);

    logic [MUL_A_W-1:0] r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [MUL_P_W-1:0] r_acc;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    // accumulate one partial product per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= '0;
                r_cnt  <= CNT_W'(MUL_B_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= {r_acc[MUL_P_W-2:0], 1'b0}
                       + (r_b[MUL_B_W-1] ? MUL_P_W'(r_a) : '0);
                r_b   <= {r_b[MUL_B_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

[hw/rtl/pgls_div.sv]
// ----------------------------------------------------------------------------
// pgls_div
// restoring divider, one quotient bit per cycle; quotient shifts into the
// numerator register as the numerator bits are consumed
// ----------------------------------------------------------------------------
module pgls_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pgls_pkg::t_div_req          i_req,
    output logic                        o_done,
    output logic [pgls_pkg::DIV_N_W-1:0] o_quot
);
    import pgls_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic [DIV_N_W-1:0] r_nq;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W-1:0] r_den;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [DIV_D_W:0]   rs;
    logic [DIV_D_W:0]   rdiff;
    logic               qbit;

    // partial remainder with the carry bit kept on top
    assign rs    = {r_rem, r_nq[DIV_N_W-1]};
    assign rdiff = rs - {1'b0, r_den};
    assign qbit  = (rs >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_nq   <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(DIV_N_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= qbit ? rdiff[DIV_D_W-1:0] : rs[DIV_D_W-1:0];
                r_nq  <= {r_nq[DIV_N_W-2:0], qbit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_nq;

endmodule

[hw/rtl/parabolic_golden_line_search_top.sv]
// ----------------------------------------------------------------------------
// parabolic_golden_line_search_top
// line search controller: start probes, bracket sort, parabolic vertex with
// golden-section fallback, stop when the bracket is within twice the tolerance
// ----------------------------------------------------------------------------
//  channel  signals                                  direction
//  cfg      i_cfg_valid o_cfg_ready i_cfg_tolerance  in
//  in       i_valid o_ready i_op i_energy            in
//  out      o_valid i_ready o_probe_step o_finished  out
//           o_best_energy
//
//  start probes and reports that only store give their result in the cycle after they are taken
//  golden step: one shift-add multiplication after the report (C_GOLD, C_GW)
//  parabolic step: six shift-add multiplications, then one restoring division,
//  ending in the golden step when the denominator is zero
//  o_ready is low while an item is at work or a result waits on the output
//  reset is synchronous and active low; cfg writes are always taken
// ----------------------------------------------------------------------------
module parabolic_golden_line_search_top #(
    parameter int FRAC_BITS = pgls_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_tolerance,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  logic signed [31:0] i_energy,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_probe_step,
    output logic               o_finished,
    output logic signed [31:0] o_best_energy
);
    import pgls_pkg::*;

    // fixed-point constants, rounded to nearest
    localparam logic [63:0] QONE   = 64'd1 << FRAC_BITS;
    localparam logic [63:0] HALF   = QONE >> 1;
    localparam logic [31:0] STEP_A = 32'((QONE + 64'd50) / 64'd100);
    localparam logic [31:0] STEP_B = 32'((64'd2 * QONE + 64'd50) / 64'd100);
    localparam logic [31:0] STEP_C = 32'((64'd3 * QONE + 64'd50) / 64'd100);
    localparam logic [31:0] GOLDEN =
        32'((QONE * 64'd3819660 + 64'd5000000) / 64'd10000000);
    localparam logic [63:0] QLIMIT = 64'd1 << 34;

    // search phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_S1   = 3'd1;
    localparam logic [2:0] PH_S2   = 3'd2;
    localparam logic [2:0] PH_S3   = 3'd3;
    localparam logic [2:0] PH_PARA = 3'd4;
    localparam logic [2:0] PH_GOLD = 3'd5;
    localparam logic [2:0] PH_DONE = 3'd6;

    // sequencer states
    localparam logic [3:0] C_WAIT = 4'd0;
    localparam logic [3:0] C_SORT = 4'd1;
    localparam logic [3:0] C_AU   = 4'd2;
    localparam logic [3:0] C_NP   = 4'd3;
    localparam logic [3:0] C_M1   = 4'd4;
    localparam logic [3:0] C_M2   = 4'd5;
    localparam logic [3:0] C_M3   = 4'd6;
    localparam logic [3:0] C_M4   = 4'd7;
    localparam logic [3:0] C_M5   = 4'd8;
    localparam logic [3:0] C_M6   = 4'd9;
    localparam logic [3:0] C_DIV  = 4'd10;
    localparam logic [3:0] C_GOLD = 4'd11;
    localparam logic [3:0] C_GW   = 4'd12;

    function automatic logic signed [31:0] f_sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) return v[32] ? 32'sh80000000 : 32'sh7fffffff;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] f_sat64(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] f_mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    function automatic logic [32:0] f_mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : v;
    endfunction

    // state
    logic signed [31:0] r_s [3];
    logic signed [31:0] r_en [3];
    logic signed [31:0] r_pend;
    logic [2:0]         r_phase;
    logic               r_left;
    logic [15:0]        r_tol;
    logic [3:0]         r_ctrl;
    logic [63:0]        r_den;
    logic [127:0]       r_num;
    logic               r_nneg;
    logic               r_ov;
    logic signed [31:0] r_o_step;
    logic               r_o_fin;
    logic signed [31:0] r_o_best;

    logic signed [31:0] n_s [3];
    logic signed [31:0] n_en [3];
    logic signed [31:0] n_pend;
    logic [2:0]         n_phase;
    logic               n_left;
    logic [3:0]         n_ctrl;
    logic [63:0]        n_den;
    logic [127:0]       n_num;
    logic               n_nneg;
    logic               n_ov;
    logic signed [31:0] n_o_step;
    logic               n_o_fin;
    logic signed [31:0] n_o_best;

    // shared units
    t_mul_req           mreq;
    t_div_req           dreq;
    logic               mul_done;
    logic [MUL_P_W-1:0] mul_p;
    logic               div_done;
    logic [DIV_N_W-1:0] div_q;

    pgls_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    pgls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dreq),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // handshakes
    logic in_acc;
    assign o_ready     = (r_ctrl == C_WAIT) && !r_ov;
    assign in_acc      = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    // bracket differences for the parabola
    logic signed [31:0] b10, b12, d12, d10;
    assign b10 = f_sat33(33'(r_s[1]) - 33'(r_s[0]));
    assign b12 = f_sat33(33'(r_s[1]) - 33'(r_s[2]));
    assign d12 = f_sat33(33'(r_en[1]) - 33'(r_en[2]));
    assign d10 = f_sat33(33'(r_en[1]) - 33'(r_en[0]));

    // golden section choice
    logic signed [32:0] g_len;
    logic [32:0]        g_len_mag;
    logic               g_left;
    logic [63:0]        g_off;
    logic signed [63:0] g_sum;
    assign g_left    = f_mag33(33'(r_s[0]) - 33'(r_s[1]))
                     > f_mag33(33'(r_s[1]) - 33'(r_s[2]));
    assign g_len     = g_left ? 33'(r_s[1]) - 33'(r_s[0])
                              : 33'(r_s[2]) - 33'(r_s[1]);
    assign g_len_mag = f_mag33(g_len);
    assign g_off     = (mul_p[63:0] + HALF) >> FRAC_BITS;
    assign g_sum     = 64'(r_s[1]) + (g_len[32] ? -$signed(g_off) : $signed(g_off));

    // signed products from the multiplier
    logic [63:0]  p_lo;
    logic [127:0] p_wide;
    logic [63:0]  den_v;
    logic [63:0]  den_mag;
    logic [127:0] num_v;
    logic [63:0]  qm;
    logic signed [63:0] q_sum;
    assign p_lo    = mul_p[63:0];
    assign p_wide  = 128'(mul_p);
    assign den_mag = r_den[63] ? -r_den : r_den;
    assign qm      = (div_q[127:64] != '0 || div_q[63:0] > QLIMIT) ? QLIMIT : div_q[63:0];
    assign q_sum   = (r_nneg ^ r_den[63]) ? 64'(r_s[1]) + $signed(qm)
                                          : 64'(r_s[1]) - $signed(qm);

    // sorted bracket after the third start probe
    logic signed [31:0] sa_s [3], sa_e [3], sb_s [3], sb_e [3];
    always_comb begin
        sa_s = r_s;
        sa_e = r_en;
        if (r_en[1] > r_en[0]) begin
            sa_s[0] = r_s[1]; sa_e[0] = r_en[1];
            sa_s[1] = r_s[0]; sa_e[1] = r_en[0];
        end
        sb_s = sa_s;
        sb_e = sa_e;
        if (sa_e[1] > sa_e[2]) begin
            sb_s[2] = sa_s[1]; sb_e[2] = sa_e[1];
            sb_s[1] = sa_s[2]; sb_e[1] = sa_e[2];
        end
    end

    // report compares for the parabolic and golden probes
    logic signed [32:0] tol_s;
    logic               e_lt1;
    assign tol_s = $signed({17'b0, r_tol});
    assign e_lt1 = i_energy < r_en[1];

    // sequencer
    always_comb begin
        n_s      = r_s;
        n_en     = r_en;
        n_pend   = r_pend;
        n_phase  = r_phase;
        n_left   = r_left;
        n_ctrl   = r_ctrl;
        n_den    = r_den;
        n_num    = r_num;
        n_nneg   = r_nneg;
        n_ov     = r_ov;
        n_o_step = r_o_step;
        n_o_fin  = r_o_fin;
        n_o_best = r_o_best;
        mreq     = '0;
        dreq     = '0;
        den_v    = r_den - ((d10[31] ^ b12[31]) ? -p_lo : p_lo);
        num_v    = r_num - (d10[31] ? -p_wide : p_wide);

        if (r_ov && i_ready) n_ov = 1'b0;

        unique case (r_ctrl)
            C_WAIT: begin
                if (in_acc) begin
                    if (!i_op) begin
                        n_s      = '{3{32'sd0}};
                        n_en     = '{3{32'sd0}};
                        n_left   = 1'b0;
                        n_pend   = STEP_A;
                        n_phase  = PH_S1;
                        n_ov     = 1'b1;
                        n_o_step = STEP_A;
                        n_o_fin  = 1'b0;
                        n_o_best = '0;
                    end else begin
                        case (r_phase)
                            PH_S1: begin
                                n_s[0]   = r_pend;
                                n_en[0]  = i_energy;
                                n_pend   = STEP_B;
                                n_phase  = PH_S2;
                                n_ov     = 1'b1;
                                n_o_step = STEP_B;
                                n_o_fin  = 1'b0;
                                n_o_best = '0;
                            end
                            PH_S2: begin
                                n_s[1]   = r_pend;
                                n_en[1]  = i_energy;
                                n_pend   = STEP_C;
                                n_phase  = PH_S3;
                                n_ov     = 1'b1;
                                n_o_step = STEP_C;
                                n_o_fin  = 1'b0;
                                n_o_best = '0;
                            end
                            PH_S3: begin
                                n_s[2]  = r_pend;
                                n_en[2] = i_energy;
                                n_ctrl  = C_SORT;
                            end
                            PH_PARA: begin
                                n_ctrl = C_AU;
                                if (e_lt1) begin
                                    if (r_en[2] > r_en[0]) begin
                                        n_s[2] = r_s[1]; n_en[2] = r_en[1];
                                    end else begin
                                        n_s[0] = r_s[1]; n_en[0] = r_en[1];
                                    end
                                    n_s[1]  = r_pend;
                                    n_en[1] = i_energy;
                                end else if (33'(r_en[2]) - 33'(i_energy) > tol_s) begin
                                    n_s[2] = r_pend; n_en[2] = i_energy;
                                end else if (33'(r_en[0]) - 33'(i_energy) > tol_s) begin
                                    n_s[0] = r_pend; n_en[0] = i_energy;
                                end else begin
                                    n_ctrl = C_GOLD;
                                end
                            end
                            PH_GOLD: begin
                                n_ctrl = C_AU;
                                if (e_lt1) begin
                                    if (r_left) begin
                                        n_s[0] = r_s[1]; n_en[0] = r_en[1];
                                    end else begin
                                        n_s[2] = r_s[1]; n_en[2] = r_en[1];
                                    end
                                    n_s[1]  = r_pend;
                                    n_en[1] = i_energy;
                                end else if (r_left) begin
                                    n_s[0] = r_pend; n_en[0] = i_energy;
                                end else begin
                                    n_s[2] = r_pend; n_en[2] = i_energy;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            C_SORT: begin
                n_s    = sb_s;
                n_en   = sb_e;
                n_ctrl = C_NP;
            end
            C_AU: begin
                if (f_mag33(33'(r_s[0]) - 33'(r_s[2])) > {16'b0, r_tol, 1'b0}) begin
                    n_ctrl = C_NP;
                end else begin
                    n_phase  = PH_DONE;
                    n_ctrl   = C_WAIT;
                    n_ov     = 1'b1;
                    n_o_step = r_s[1];
                    n_o_fin  = 1'b1;
                    n_o_best = r_en[1];
                end
            end
            C_NP: begin
                mreq.start = 1'b1;
                mreq.a     = 64'(f_mag32(b10));
                mreq.b     = f_mag32(d12);
                n_ctrl     = C_M1;
            end
            C_M1: begin
                if (mul_done) begin
                    n_den      = (b10[31] ^ d12[31]) ? -p_lo : p_lo;
                    mreq.start = 1'b1;
                    mreq.a     = 64'(f_mag32(b12));
                    mreq.b     = f_mag32(d10);
                    n_ctrl     = C_M2;
                end
            end
            C_M2: begin
                if (mul_done) begin
                    n_den = den_v;
                    if (den_v == '0) begin
                        n_ctrl = C_GOLD;
                    end else begin
                        mreq.start = 1'b1;
                        mreq.a     = 64'(f_mag32(b10));
                        mreq.b     = f_mag32(b10);
                        n_ctrl     = C_M3;
                    end
                end
            end
            C_M3: begin
                if (mul_done) begin
                    mreq.start = 1'b1;
                    mreq.a     = p_lo;
                    mreq.b     = f_mag32(d12);
                    n_ctrl     = C_M4;
                end
            end
            C_M4: begin
                if (mul_done) begin
                    n_num      = d12[31] ? -p_wide : p_wide;
                    mreq.start = 1'b1;
                    mreq.a     = 64'(f_mag32(b12));
                    mreq.b     = f_mag32(b12);
                    n_ctrl     = C_M5;
                end
            end
            C_M5: begin
                if (mul_done) begin
                    mreq.start = 1'b1;
                    mreq.a     = p_lo;
                    mreq.b     = f_mag32(d10);
                    n_ctrl     = C_M6;
                end
            end
            C_M6: begin
                if (mul_done) begin
                    n_nneg     = num_v[127];
                    dreq.start = 1'b1;
                    dreq.num   = num_v[127] ? -num_v : num_v;
                    dreq.den   = {den_mag[62:0], 1'b0};
                    n_ctrl     = C_DIV;
                end
            end
            C_DIV: begin
                if (div_done) begin
                    n_pend   = f_sat64(q_sum);
                    n_phase  = PH_PARA;
                    n_ctrl   = C_WAIT;
                    n_ov     = 1'b1;
                    n_o_step = f_sat64(q_sum);
                    n_o_fin  = 1'b0;
                    n_o_best = r_en[1];
                end
            end
            C_GOLD: begin
                n_left     = g_left;
                mreq.start = 1'b1;
                mreq.a     = 64'(g_len_mag);
                mreq.b     = GOLDEN;
                n_ctrl     = C_GW;
            end
            C_GW: begin
                if (mul_done) begin
                    n_pend   = f_sat64(g_sum);
                    n_phase  = PH_GOLD;
                    n_ctrl   = C_WAIT;
                    n_ov     = 1'b1;
                    n_o_step = f_sat64(g_sum);
                    n_o_fin  = 1'b0;
                    n_o_best = r_en[1];
                end
            end
            default: n_ctrl = C_WAIT;
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s     <= '{3{32'sd0}};
            r_en    <= '{3{32'sd0}};
            r_pend  <= '0;
            r_phase <= PH_IDLE;
            r_left  <= 1'b0;
            r_tol   <= TOL_RESET;
            r_ctrl  <= C_WAIT;
            r_ov    <= 1'b0;
        end else begin
            r_s     <= n_s;
            r_en    <= n_en;
            r_pend  <= n_pend;
            r_phase <= n_phase;
            r_left  <= n_left;
            r_ctrl  <= n_ctrl;
            r_ov    <= n_ov;
            if (i_cfg_valid) r_tol <= i_cfg_tolerance;
        end
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        r_den    <= n_den;
        r_num    <= n_num;
        r_nneg   <= n_nneg;
        r_o_step <= n_o_step;
        r_o_fin  <= n_o_fin;
        r_o_best <= n_o_best;
    end

    assign o_valid       = r_ov;
    assign o_probe_step  = r_o_step;
    assign o_finished    = r_o_fin;
    assign o_best_energy = r_o_best;

    // a result only appears when the sequencer is back to waiting
    a_emit_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> r_ctrl == C_WAIT)
        else $error("result raised outside the wait state");

    // no pending result while an item is at work
    a_busy_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctrl != C_WAIT |-> !r_ov)
        else $error("result pending during item processing");

    // a finished result goes with the done phase
    a_fin_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_fin) |-> r_phase == PH_DONE)
        else $error("finished flag without done phase");

    // divider completes only while the sequencer waits for it
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_ctrl == C_DIV)
        else $error("divider done outside divide state");

endmodule

[test/parabolic_golden_line_search_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// parabolic_golden_line_search_top_tb
// drives start and energy-report items into the line search controller,
// predicts every probe step and final result in a local bit-exact model of
// the search and compares each output item field by field
// ----------------------------------------------------------------------------
module parabolic_golden_line_search_top_tb;

    localparam int FB = 16;
    localparam logic OP_START = 1'b0;
    localparam logic OP_REPORT = 1'b1;
    localparam longint STEP_A = ((longint'(1) << FB) + 50) / 100;
    localparam longint STEP_B = ((longint'(2) << FB) + 50) / 100;
    localparam longint STEP_C = ((longint'(3) << FB) + 50) / 100;
    localparam longint GOLD = ((longint'(1) << FB) * 3819660 + 5000000) / 10000000;
    localparam longint QLIM = longint'(1) << 34;
    localparam longint LIMIT_CYCLES = 2000000;

    typedef enum int {
        PH_IDLE, PH_START1, PH_START2, PH_START3, PH_PARA, PH_GOLD, PH_DONE
    } t_phase;

    typedef struct {
        logic signed [31:0] step;
        logic               fin;
        logic signed [31:0] best;
    } t_probe;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [15:0] i_cfg_tolerance = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_op = 1'b0;
    logic signed [31:0] i_energy = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [31:0] o_probe_step;
    logic o_finished;
    logic signed [31:0] o_best_energy;

    parabolic_golden_line_search_top dut (.*);

    // predictor state
    longint br_step[3];
    longint br_en[3];
    longint pend_step;
    t_phase phase;
    bit     gold_left;
    longint tol;

    t_probe expected_probes[$];
    int     n_errors = 0;
    int     n_results = 0;
    int     n_finished = 0;
    int     n_items = 0;
    longint cycle = 0;
    bit     hold_rx = 1'b0;

    // clock and watchdog
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT_CYCLES) begin
            $display("parabolic_golden_line_search_top: mismatch");
            $finish;
        end
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint absval(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void push_probe(longint s, bit f, longint e);
        t_probe p;
        p.step = s[31:0];
        p.fin = f;
        p.best = e[31:0];
        expected_probes.push_back(p);
    endfunction

    function automatic void golden_step();
        longint len, prod, off;
        bit lft;
        lft = absval(br_step[0] - br_step[1]) > absval(br_step[1] - br_step[2]);
        len = lft ? br_step[1] - br_step[0] : br_step[2] - br_step[1];
        prod = len * GOLD;
        off = (absval(prod) + (longint'(1) << (FB - 1))) >>> FB;
        if (prod < 0) off = -off;
        gold_left = lft;
        pend_step = sat32(br_step[1] + off);
        phase = PH_GOLD;
        push_probe(pend_step, 1'b0, br_en[1]);
    endfunction

    // parabolic vertex with exact wide numerator
    function automatic void parabola_step();
        longint b10, b12, d12, d10, den, qm;
        logic signed [127:0] num;
        logic [127:0] nmag, q;
        logic [63:0] dm2;
        bit nneg, qneg;
        b10 = sat32(br_step[1] - br_step[0]);
        b12 = sat32(br_step[1] - br_step[2]);
        d12 = sat32(br_en[1] - br_en[2]);
        d10 = sat32(br_en[1] - br_en[0]);
        den = b10 * d12 - b12 * d10;
        if (den == 0) begin
            golden_step();
            return;
        end
        num = 128'(b10 * b10) * 128'(d12) - 128'(b12 * b12) * 128'(d10);
        nneg = num[127];
        nmag = nneg ? -num : num;
        // doubled denominator magnitude wraps at 64 bits; zero gives all ones
        dm2 = 64'(absval(den)) << 1;
        q = (dm2 == 64'd0) ? '1 : nmag / {64'd0, dm2};
        qm = (q > 128'(QLIM)) ? QLIM : longint'(q[63:0]);
        qneg = nneg != (den < 0);
        pend_step = sat32(qneg ? br_step[1] + qm : br_step[1] - qm);
        phase = PH_PARA;
        push_probe(pend_step, 1'b0, br_en[1]);
    endfunction

    function automatic void after_update();
        if (absval(br_step[0] - br_step[2]) > 2 * tol) begin
            parabola_step();
        end else begin
            phase = PH_DONE;
            push_probe(br_step[1], 1'b1, br_en[1]);
        end
    endfunction

    function automatic void put(int k, longint s, longint e);
        br_step[k] = s;
        br_en[k] = e;
    endfunction

    function automatic void swap_mid(int k);
        longint s, e;
        s = br_step[k];
        e = br_en[k];
        put(k, br_step[1], br_en[1]);
        put(1, s, e);
    endfunction

    function automatic void predict_search(logic op, logic signed [31:0] energy);
        longint e;
        e = energy;
        if (op == OP_START) begin
            for (int k = 0; k < 3; k++) put(k, 0, 0);
            gold_left = 1'b0;
            pend_step = STEP_A;
            phase = PH_START1;
            push_probe(pend_step, 1'b0, 0);
            return;
        end
        case (phase)
            PH_START1: begin
                put(0, pend_step, e);
                pend_step = STEP_B;
                phase = PH_START2;
                push_probe(pend_step, 1'b0, 0);
            end
            PH_START2: begin
                put(1, pend_step, e);
                pend_step = STEP_C;
                phase = PH_START3;
                push_probe(pend_step, 1'b0, 0);
            end
            PH_START3: begin
                put(2, pend_step, e);
                if (br_en[1] > br_en[0]) swap_mid(0);
                if (br_en[1] > br_en[2]) swap_mid(2);
                parabola_step();
            end
            PH_PARA: begin
                if (e < br_en[1]) begin
                    if (br_en[2] > br_en[0]) put(2, br_step[1], br_en[1]);
                    else put(0, br_step[1], br_en[1]);
                    put(1, pend_step, e);
                    after_update();
                end else if (br_en[2] - e > tol) begin
                    put(2, pend_step, e);
                    after_update();
                end else if (br_en[0] - e > tol) begin
                    put(0, pend_step, e);
                    after_update();
                end else begin
                    golden_step();
                end
            end
            PH_GOLD: begin
                if (e < br_en[1]) begin
                    put(gold_left ? 0 : 2, br_step[1], br_en[1]);
                    put(1, pend_step, e);
                end else begin
                    put(gold_left ? 0 : 2, pend_step, e);
                end
                after_update();
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint exp_v);
        n_errors++;
        if (n_errors <= 30)
            $display("error at cycle %0d: %s got %0d expected %0d", cycle, what, got, exp_v);
    endtask

    // receiver with random stalls and an optional long hold
    initial begin
        int gap;
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                i_ready <= 1'b0;
            end else if (!i_ready || (o_valid && i_ready)) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                i_ready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_probe p;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (expected_probes.size() == 0) begin
                report_mismatch("unexpected result step", o_probe_step, 0);
            end else begin
                p = expected_probes.pop_front();
                if (o_finished) n_finished++;
                if (o_probe_step !== p.step)
                    report_mismatch("probe_step", o_probe_step, p.step);
                if (o_finished !== p.fin)
                    report_mismatch("finished", o_finished, p.fin);
                if (o_best_energy !== p.best)
                    report_mismatch("best_energy", o_best_energy, p.best);
            end
        end
    end

    // one item on the input channel, with a random gap ahead of it
    task automatic send_item(logic op, logic signed [31:0] energy, bit nogap = 0);
        int gap;
        gap = nogap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
        // let the drop of valid after the previous item take effect first
        if (i_valid) @(posedge i_clk);
        repeat (gap) @(posedge i_clk);
        i_valid <= 1'b1;
        i_op <= op;
        i_energy <= energy;
        do @(posedge i_clk); while (!o_ready);
        predict_search(op, energy);
        n_items++;
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_probes.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [15:0] v);
        wait_drained();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_tolerance <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        tol = v;
        i_cfg_valid <= 1'b0;
    endtask

    // convex-ish energy near a random minimum, with noise
    function automatic logic signed [31:0] bowl_energy(longint s, longint m, int k);
        longint d, v;
        d = s - m;
        v = ((d >>> 4) * (d >>> 4)) >>> k;
        v = v + $signed($urandom_range(0, 64)) - 32;
        return 32'(sat32(v));
    endfunction

    task automatic run_search(int max_reports, bit random_energy);
        longint m;
        int k;
        m = $signed($urandom_range(0, 8000)) - 2000;
        k = $urandom_range(0, 6);
        send_item(OP_START, $urandom());
        for (int i = 0; i < max_reports; i++) begin
            while (expected_probes.size() != 0) @(posedge i_clk);
            if (phase == PH_DONE) break;
            if (random_energy) send_item(OP_REPORT, $urandom());
            else send_item(OP_REPORT, bowl_energy(pend_step, m, k));
        end
    endtask

    task automatic test_directed();
        logic signed [31:0] ext[4];
        ext = '{32'sh7fffffff, 32'sh80000000, 0, -1};
        send_item(OP_REPORT, 5);
        foreach (ext[a]) begin
            send_item(OP_START, ext[a]);
            send_item(OP_REPORT, ext[a]);
            send_item(OP_REPORT, ext[(a + 1) % 4]);
            send_item(OP_REPORT, ext[(a + 2) % 4]);
            send_item(OP_REPORT, ext[(a + 3) % 4]);
        end
        // flat energies: zero denominator
        send_item(OP_START, 0);
        repeat (4) send_item(OP_REPORT, 100);
        wait_drained();
    endtask

    task automatic test_searches(int n_target);
        while (n_items < n_target) begin
            case ($urandom_range(0, 9))
                0: run_search($urandom_range(1, 6), 1);
                1: send_item(OP_REPORT, $urandom());
                default: run_search(60, 0);
            endcase
        end
    endtask

    // receiver holds off while items keep coming
    task automatic test_backpressure();
        wait_drained();
        hold_rx = 1'b1;
        fork
            begin
                send_item(OP_START, 0, 1);
                send_item(OP_REPORT, 300, 1);
                send_item(OP_REPORT, 100, 1);
                send_item(OP_REPORT, 200, 1);
            end
            begin
                repeat (300) @(posedge i_clk);
                hold_rx = 1'b0;
            end
        join
        wait_drained();
    endtask

    initial begin
        phase = PH_IDLE;
        tol = 7;
        pend_step = 0;
        gold_left = 1'b0;
        for (int k = 0; k < 3; k++) put(k, 0, 0);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        write_tolerance(16'd0);
        test_searches(300);
        write_tolerance(16'hffff);
        test_searches(500);
        write_tolerance(16'd40);
        test_searches(900);
        write_tolerance(16'd7);
        test_searches(1250);
        wait_drained();
        $display("covered %0d items, %0d results, %0d finished searches",
                 n_items, n_results, n_finished);
        $display("tolerance 0, 7, 40 and 65535, backpressure and stray reports");
        if (n_errors == 0 && expected_probes.size() == 0) begin
            $display("parabolic_golden_line_search_top: match");
        end else begin
            $display("parabolic_golden_line_search_top: mismatch");
        end
        $finish;
    end

endmodule
